>>> rtl/tlb_repl_pkg.sv
// Shared types and constants for the TLB with FIFO/LRU replacement.
// No dependencies; imported by tlb_fifo_lru_replacement_unit.
`timescale 1ns / 1ps
`default_nettype none

package tlb_repl_pkg;

    // Operation codes carried on the request channel
    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_REPLACE_MODE   = 1'b0,
        REG_ENTRIES_IN_USE = 1'b1
    } cfg_reg_t;

    // Replacement policy codes
    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    localparam int CFG_DATA_W  = 5;
    localparam int ENT_CFG_W   = 5;
    localparam int STAMP_W     = 32;
    localparam int INDEX_OUT_W = 4;

    localparam logic [ENT_CFG_W-1:0] ENT_CFG_RESET = 5'd16;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_PAGE_BITS  = 20;
    localparam int DEF_FRAME_BITS = 20;

endpackage

`default_nettype wire

>>> rtl/tlb_fifo_lru_replacement_unit.sv
// Fully associative TLB with FIFO or LRU replacement, sequential scan engine.
// Depends on tlb_repl_pkg (op codes, register indexes, widths).
`timescale 1ns / 1ps
`default_nettype none

// A lookup or insert walks the active entries one per cycle through a single
// compare unit fed by the entry memory's one read port. With n the clamped
// entry count, an insert or a lookup miss compares all n entries before the
// unit takes its next request; a lookup that hits entry j stops there. Flush
// and the unused op skip the scan. A finished result moves into the output
// register as the unit goes ready again; while that register still holds an
// untaken result, the unit waits in its output state until m_ready frees it.
// Lookups report the lowest matching valid entry; in LRU mode a hit restamps
// it. Inserts take the lowest free entry, else the oldest stamp (lowest index
// on a tie). Stamps come from a saturating 32-bit counter that flush clears.
// Configuration writes are taken every cycle and must only be issued while the
// unit is idle.
module tlb_fifo_lru_replacement_unit
    import tlb_repl_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int PAGE_BITS  = DEF_PAGE_BITS,
    parameter int FRAME_BITS = DEF_FRAME_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration write channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [0:0]             cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // request channel
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [1:0]             s_op,
    input  wire logic [PAGE_BITS-1:0]   s_page,
    input  wire logic [FRAME_BITS-1:0]  s_frame,
    // result channel
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_hit,
    output logic [FRAME_BITS-1:0]       m_frame_out,
    output logic [INDEX_OUT_W-1:0]      m_entry_index
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } state_t;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [PAGE_BITS-1:0]   page_reg, page_next;
    logic [FRAME_BITS-1:0]  frame_reg, frame_next;
    logic [CNT_W-1:0]       n_reg, n_next;

    logic                   mode_reg, mode_next;
    logic [ENT_CFG_W-1:0]   entries_reg, entries_next;

    logic [ENTRIES-1:0]     valid_reg, valid_next;
    logic [STAMP_W-1:0]     stamp_cnt_reg, stamp_cnt_next;

    // scan pipeline: issue stage then compare stage
    logic [IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                   issue_live_reg, issue_live_next;
    logic                   cmp_live_reg, cmp_live_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   cmp_valid_reg, cmp_valid_next;

    // victim search for insert
    logic                   free_found_reg, free_found_next;
    logic                   best_seen_reg, best_seen_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [STAMP_W-1:0]     best_stamp_reg, best_stamp_next;

    // finished result waiting for the output register
    logic                   res_hit_reg, res_hit_next;
    logic [FRAME_BITS-1:0]  res_frame_reg, res_frame_next;
    logic [IDX_W-1:0]       res_idx_reg, res_idx_next;

    logic                   m_valid_reg, m_valid_next;
    logic                   m_hit_reg, m_hit_next;
    logic [FRAME_BITS-1:0]  m_frame_reg, m_frame_next;
    logic [IDX_W-1:0]       m_idx_reg, m_idx_next;

    // entry memories, registered read data
    logic [PAGE_BITS-1:0]   page_mem  [ENTRIES];
    logic [FRAME_BITS-1:0]  frame_mem [ENTRIES];
    logic [STAMP_W-1:0]     stamp_mem [ENTRIES];
    logic [PAGE_BITS-1:0]   rd_page_reg;
    logic [FRAME_BITS-1:0]  rd_frame_reg;
    logic [STAMP_W-1:0]     rd_stamp_reg;

    // memory write controls
    logic                   mem_we;
    logic                   stamp_we;
    logic [IDX_W-1:0]       wr_idx;

    // misc combinational
    logic                   s_xfer;
    logic                   cfg_xfer;
    logic [CNT_W-1:0]       n_eff;
    logic [CNT_W-1:0]       n_last;
    logic                   issue_last;
    logic                   cmp_last;
    logic                   page_match;
    logic [STAMP_W-1:0]     stamp_adv;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_xfer    = s_valid && s_ready;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_frame_out   = m_frame_reg;
    assign m_entry_index = INDEX_OUT_W'(m_idx_reg);

    // Clamp the entry count: zero acts as one, above ENTRIES acts as ENTRIES
    always_comb begin
        if (entries_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(entries_reg) > 32'(ENTRIES)) begin
            n_eff = CNT_W'(ENTRIES);
        end else begin
            n_eff = CNT_W'(entries_reg);
        end
    end

    assign n_last     = n_reg - CNT_W'(1);
    assign issue_last = (CNT_W'(scan_idx_reg) == n_last);
    assign cmp_last   = (CNT_W'(cmp_idx_reg) == n_last);
    assign page_match = cmp_live_reg && cmp_valid_reg && (rd_page_reg == page_reg);
    assign stamp_adv  = (stamp_cnt_reg == STAMP_MAX) ? stamp_cnt_reg
                                                     : stamp_cnt_reg + STAMP_W'(1);

    // ---------------------------------------------------------------
    // Sequencer next-state logic
    // ---------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        page_next       = page_reg;
        frame_next      = frame_reg;
        n_next          = n_reg;
        mode_next       = mode_reg;
        entries_next    = entries_reg;
        valid_next      = valid_reg;
        stamp_cnt_next  = stamp_cnt_reg;
        scan_idx_next   = scan_idx_reg;
        issue_live_next = issue_live_reg;
        cmp_live_next   = 1'b0;
        cmp_idx_next    = scan_idx_reg;
        cmp_valid_next  = valid_reg[scan_idx_reg];
        free_found_next = free_found_reg;
        best_seen_next  = best_seen_reg;
        best_idx_next   = best_idx_reg;
        best_stamp_next = best_stamp_reg;
        res_hit_next    = res_hit_reg;
        res_frame_next  = res_frame_reg;
        res_idx_next    = res_idx_reg;
        m_valid_next    = m_valid_reg;
        m_hit_next      = m_hit_reg;
        m_frame_next    = m_frame_reg;
        m_idx_next      = m_idx_reg;
        mem_we          = 1'b0;
        stamp_we        = 1'b0;
        wr_idx          = cmp_idx_reg;

        // configuration writes
        if (cfg_xfer) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_REPLACE_MODE:   mode_next    = cfg_data[0];
                REG_ENTRIES_IN_USE: entries_next = cfg_data[ENT_CFG_W-1:0];
                default:            ;
            endcase
        end

        // output register drains independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    op_next         = op_t'(s_op);
                    page_next       = s_page;
                    frame_next      = s_frame;
                    n_next          = n_eff;
                    scan_idx_next   = '0;
                    free_found_next = 1'b0;
                    best_seen_next  = 1'b0;
                    best_idx_next   = '0;
                    res_hit_next    = 1'b0;
                    res_frame_next  = '0;
                    res_idx_next    = '0;
                    unique case (op_t'(s_op))
                        OP_LOOKUP, OP_INSERT: begin
                            issue_live_next = 1'b1;
                            state_next      = ST_SCAN;
                        end
                        OP_FLUSH: begin
                            valid_next     = '0;
                            stamp_cnt_next = '0;
                            state_next     = ST_OUT;
                        end
                        OP_NOP: begin
                            state_next = ST_OUT;
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            end

            ST_SCAN: begin
                // issue stage: read one entry per cycle
                cmp_live_next = issue_live_reg;
                if (issue_live_reg) begin
                    if (issue_last) begin
                        issue_live_next = 1'b0;
                    end else begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                end

                // compare stage
                if (cmp_live_reg) begin
                    if (op_reg == OP_LOOKUP) begin
                        if (page_match) begin
                            res_hit_next    = 1'b1;
                            res_frame_next  = rd_frame_reg;
                            res_idx_next    = cmp_idx_reg;
                            issue_live_next = 1'b0;
                            cmp_live_next   = 1'b0;
                            state_next      = ST_OUT;
                            if (mode_reg == MODE_LRU) begin
                                stamp_we       = 1'b1;
                                wr_idx         = cmp_idx_reg;
                                stamp_cnt_next = stamp_adv;
                            end
                        end else if (cmp_last) begin
                            cmp_live_next = 1'b0;
                            state_next    = ST_OUT;
                        end
                    end else begin
                        // insert: lowest free entry, else oldest stamp
                        if (!free_found_reg) begin
                            if (!cmp_valid_reg) begin
                                free_found_next = 1'b1;
                                best_idx_next   = cmp_idx_reg;
                            end else if (!best_seen_reg || rd_stamp_reg < best_stamp_reg) begin
                                best_seen_next  = 1'b1;
                                best_idx_next   = cmp_idx_reg;
                                best_stamp_next = rd_stamp_reg;
                            end
                        end
                        if (cmp_last) begin
                            mem_we                    = 1'b1;
                            stamp_we                  = 1'b1;
                            wr_idx                    = best_idx_next;
                            valid_next[best_idx_next] = 1'b1;
                            stamp_cnt_next            = stamp_adv;
                            res_idx_next              = best_idx_next;
                            cmp_live_next             = 1'b0;
                            state_next                = ST_OUT;
                        end
                    end
                end
            end

            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = res_hit_reg;
                    m_frame_next = res_frame_reg;
                    m_idx_next   = res_idx_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // State and registered outputs
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_FIFO;
            entries_reg    <= ENT_CFG_RESET;
            valid_reg      <= '0;
            stamp_cnt_reg  <= '0;
            issue_live_reg <= 1'b0;
            cmp_live_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            scan_idx_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            entries_reg    <= entries_next;
            valid_reg      <= valid_next;
            stamp_cnt_reg  <= stamp_cnt_next;
            issue_live_reg <= issue_live_next;
            cmp_live_reg   <= cmp_live_next;
            m_valid_reg    <= m_valid_next;
            scan_idx_reg   <= scan_idx_next;
        end
        op_reg         <= op_next;
        page_reg       <= page_next;
        frame_reg      <= frame_next;
        n_reg          <= n_next;
        cmp_idx_reg    <= cmp_idx_next;
        cmp_valid_reg  <= cmp_valid_next;
        free_found_reg <= free_found_next;
        best_seen_reg  <= best_seen_next;
        best_idx_reg   <= best_idx_next;
        best_stamp_reg <= best_stamp_next;
        res_hit_reg    <= res_hit_next;
        res_frame_reg  <= res_frame_next;
        res_idx_reg    <= res_idx_next;
        m_hit_reg      <= m_hit_next;
        m_frame_reg    <= m_frame_next;
        m_idx_reg      <= m_idx_next;
    end

    // ---------------------------------------------------------------
    // Entry memories: one write port, one read port
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            page_mem[wr_idx]  <= page_reg;
            frame_mem[wr_idx] <= frame_reg;
        end
        if (stamp_we) begin
            stamp_mem[wr_idx] <= stamp_cnt_reg;
        end
        rd_page_reg  <= page_mem[scan_idx_reg];
        rd_frame_reg <= frame_mem[scan_idx_reg];
        rd_stamp_reg <= stamp_mem[scan_idx_reg];
    end

`ifndef SYNTHESIS
    // scan engine is quiet whenever a new request can be taken
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!issue_live_reg && !cmp_live_reg))
        else $error("scan activity while accepting requests");

    // flush empties the table and restarts the stamp counter
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && (op_t'(s_op) == OP_FLUSH)) |=> (valid_reg == '0 && stamp_cnt_reg == '0))
        else $error("flush did not clear entries");

    // stamp counter only moves forward between flushes
    a_stamp_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_xfer && (op_t'(s_op) == OP_FLUSH)) |=> (stamp_cnt_reg >= $past(stamp_cnt_reg)))
        else $error("stamp counter went backwards");

    // a hit always names an entry inside the active range
    a_hit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_hit_reg) |-> (CNT_W'(m_idx_reg) < n_reg))
        else $error("hit index outside active entries");

    // an insert leaves its target entry valid
    a_insert_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && (state_reg == ST_SCAN)) |=> (valid_reg != '0))
        else $error("insert did not mark an entry valid");
`endif

endmodule

`default_nettype wire

>>> test/tlb_repl_checker.sv
// Scoreboard for the FIFO/LRU TLB: watches the config, request and response
// channels, predicts each response and compares it. Depends on tlb_repl_pkg.
`timescale 1ns / 1ps

module tlb_repl_checker
    import tlb_repl_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    input  wire logic                      cfg_ready,
    input  wire logic [0:0]                cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                      s_valid,
    input  wire logic                      s_ready,
    input  wire logic [1:0]                s_op,
    input  wire logic [DEF_PAGE_BITS-1:0]  s_page,
    input  wire logic [DEF_FRAME_BITS-1:0] s_frame,
    input  wire logic                      m_valid,
    input  wire logic                      m_ready,
    input  wire logic                      m_hit,
    input  wire logic [DEF_FRAME_BITS-1:0] m_frame_out,
    input  wire logic [INDEX_OUT_W-1:0]    m_entry_index,
    output int                             errors,
    output int                             pending,
    output int                             checked,
    output int                             hits,
    output int                             evictions
);

    typedef struct packed {
        logic                      hit;
        logic [DEF_FRAME_BITS-1:0] frame;
        logic [INDEX_OUT_W-1:0]    index;
    } tlb_resp_t;

    // Shadow copy of the translation table and its settings
    logic                      shadow_valid [DEF_ENTRIES];
    logic [DEF_PAGE_BITS-1:0]  shadow_page  [DEF_ENTRIES];
    logic [DEF_FRAME_BITS-1:0] shadow_frame [DEF_ENTRIES];
    logic [STAMP_W-1:0]        shadow_stamp [DEF_ENTRIES];
    logic [STAMP_W-1:0]        age_counter;
    logic                      policy;
    logic [ENT_CFG_W-1:0]      entry_limit;

    tlb_resp_t resp_q[$];

    initial begin
        errors    = 0;
        pending   = 0;
        checked   = 0;
        hits      = 0;
        evictions = 0;
    end

    function automatic void clear_table();
        for (int i = 0; i < DEF_ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_page[i]  = '0;
            shadow_frame[i] = '0;
            shadow_stamp[i] = '0;
        end
        age_counter = '0;
    endfunction

    // Saturating stamp: hand out the current value, then advance
    function automatic logic [STAMP_W-1:0] next_age();
        logic [STAMP_W-1:0] s;
        s = age_counter;
        if (age_counter != '1)
            age_counter = age_counter + 1'b1;
        return s;
    endfunction

    // Out-of-range entry counts clamp to 1..DEF_ENTRIES
    function automatic int active_entries();
        if (entry_limit == 0)
            return 1;
        if (entry_limit > DEF_ENTRIES)
            return DEF_ENTRIES;
        return int'(entry_limit);
    endfunction

    // Apply one request to the shadow table and return its response
    function automatic tlb_resp_t translate_and_update(op_t op,
                                                       logic [DEF_PAGE_BITS-1:0] pg,
                                                       logic [DEF_FRAME_BITS-1:0] fr);
        tlb_resp_t r;
        int        n;
        int        slot;
        r = '0;
        n = active_entries();
        case (op)
            OP_LOOKUP: begin
                for (int i = 0; i < n && !r.hit; i++) begin
                    if (shadow_valid[i] && shadow_page[i] == pg) begin
                        r.hit   = 1'b1;
                        r.frame = shadow_frame[i];
                        r.index = INDEX_OUT_W'(i);
                        if (policy == MODE_LRU)
                            shadow_stamp[i] = next_age();
                    end
                end
                if (r.hit)
                    hits++;
            end
            OP_INSERT: begin
                slot = -1;
                for (int i = 0; i < n; i++)
                    if (!shadow_valid[i] && slot < 0)
                        slot = i;
                // no free entry: oldest stamp goes, lowest index on a tie
                if (slot < 0) begin
                    slot = 0;
                    for (int i = 1; i < n; i++)
                        if (shadow_stamp[i] < shadow_stamp[slot])
                            slot = i;
                    evictions++;
                end
                shadow_valid[slot] = 1'b1;
                shadow_page[slot]  = pg;
                shadow_frame[slot] = fr;
                shadow_stamp[slot] = next_age();
                r.index = INDEX_OUT_W'(slot);
            end
            OP_FLUSH: clear_table();
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        tlb_resp_t want;
        if (!aresetn) begin
            clear_table();
            policy      = MODE_FIFO;
            entry_limit = ENT_CFG_RESET;
            resp_q.delete();
            pending = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_reg_t'(cfg_index) == REG_REPLACE_MODE)
                    policy = cfg_data[0];
                else
                    entry_limit = cfg_data;
            end

            // responses are older than any request accepted this cycle
            if (m_valid && m_ready) begin
                if (resp_q.size() == 0) begin
                    $error("response with nothing outstanding: hit %0d frame %h index %0d",
                           m_hit, m_frame_out, m_entry_index);
                    errors++;
                end else begin
                    want = resp_q.pop_front();
                    checked++;
                    if (m_hit !== want.hit) begin
                        $error("hit mismatch: expected %0d, got %0d", want.hit, m_hit);
                        errors++;
                    end
                    if (m_frame_out !== want.frame) begin
                        $error("frame_out mismatch: expected %h, got %h",
                               want.frame, m_frame_out);
                        errors++;
                    end
                    if (m_entry_index !== want.index) begin
                        $error("entry_index mismatch: expected %0d, got %0d",
                               want.index, m_entry_index);
                        errors++;
                    end
                end
            end

            if (s_valid && s_ready)
                resp_q.push_back(translate_and_update(op_t'(s_op), s_page, s_frame));

            pending = resp_q.size();
        end
    end

endmodule

>>> test/testbench.sv
// Top of the TLB bench: clock, reset, stimulus, flow control and verdict.
// Depends on tlb_repl_pkg, tlb_fifo_lru_replacement_unit and tlb_repl_checker.
`timescale 1ns / 1ps

module testbench;
    import tlb_repl_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE       = 25;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_ITEMS  = 60;

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [0:0]                cfg_index     = '0;
    logic [CFG_DATA_W-1:0]     cfg_data      = '0;
    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_op          = '0;
    logic [DEF_PAGE_BITS-1:0]  s_page        = '0;
    logic [DEF_FRAME_BITS-1:0] s_frame       = '0;
    logic                      m_valid;
    logic                      m_ready       = 1'b0;
    logic                      m_hit;
    logic [DEF_FRAME_BITS-1:0] m_frame_out;
    logic [INDEX_OUT_W-1:0]    m_entry_index;

    int errors, pending, checked, hits, evictions;

    // flow-control knobs shared by the stimulus and the response side
    bit calm      = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int rx_gap    = 0;
    int gap_pct   = 20;
    int sent      = 0;
    int settings  = 0;
    int idle_run  = 0;

    logic [DEF_PAGE_BITS-1:0] page_pool[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    tlb_fifo_lru_replacement_unit dut (
        .aclk, .aresetn,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_op, .s_page, .s_frame,
        .m_valid, .m_ready, .m_hit, .m_frame_out, .m_entry_index
    );

    tlb_repl_checker chk (
        .aclk, .aresetn,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_op, .s_page, .s_frame,
        .m_valid, .m_ready, .m_hit, .m_frame_out, .m_entry_index,
        .errors, .pending, .checked, .hits, .evictions
    );

    // Watchdog: too long without any transfer on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= IDLE_LIMIT) begin
            $display("FAIL tlb_fifo_lru_replacement_unit");
            $finish;
        end
    end

    // Response side: one long hold when asked, otherwise random stall bursts
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap = rx_gap - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(0, 13);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_req(op_t op, logic [DEF_PAGE_BITS-1:0] pg,
                            logic [DEF_FRAME_BITS-1:0] fr);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_op    <= op;
        s_page  <= pg;
        s_frame <= fr;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sent++;
        if (op == OP_INSERT) begin
            page_pool.push_back(pg);
            if (page_pool.size() > 24)
                void'(page_pool.pop_front());
        end
    endtask

    task automatic sender_gap(int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    // Stop offering and wait until every outstanding response is back
    task automatic wait_responses();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
    endtask

    // Register writes only once the table is quiet
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        wait_responses();
        repeat (SETTLE) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_policy(logic mode, logic [CFG_DATA_W-1:0] count);
        write_reg(REG_REPLACE_MODE, CFG_DATA_W'(mode));
        write_reg(REG_ENTRIES_IN_USE, count);
        settings++;
    endtask

    // Mostly pages that were inserted recently, so lookups hit and
    // duplicates appear; the rest small or fully random pages
    task automatic random_req();
        int                        r;
        op_t                       op;
        logic [DEF_PAGE_BITS-1:0]  pg;
        logic [DEF_FRAME_BITS-1:0] fr;
        r = $urandom_range(0, 99);
        if (r < 4)
            op = OP_FLUSH;
        else if (r < 8)
            op = OP_NOP;
        else if (r < 48)
            op = OP_INSERT;
        else
            op = OP_LOOKUP;
        r = $urandom_range(0, 99);
        if (r < 65 && page_pool.size() > 0)
            pg = page_pool[$urandom_range(0, page_pool.size() - 1)];
        else if (r < 80)
            pg = DEF_PAGE_BITS'($urandom_range(0, 15));
        else
            pg = DEF_PAGE_BITS'($urandom);
        case ($urandom_range(0, 9))
            0:       fr = '0;
            1:       fr = '1;
            default: fr = DEF_FRAME_BITS'($urandom);
        endcase
        send_req(op, pg, fr);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
            sender_gap($urandom_range(1, 14));
    endtask

    initial begin
        logic                 modes  [9];
        logic [CFG_DATA_W-1:0] counts [9];
        modes  = '{MODE_FIFO, MODE_LRU, MODE_LRU, MODE_FIFO, MODE_LRU,
                   MODE_FIFO, MODE_LRU, MODE_LRU, MODE_FIFO};
        counts = '{5'd16, 5'd16, 5'd1, 5'd3, 5'd0, 5'd31, 5'd17, 5'd8, 5'd16};

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // FIFO over four entries: empty miss, extremes, duplicate page,
        // replacement of the oldest, no-op and flush
        set_policy(MODE_FIFO, 5'd4);
        send_req(OP_LOOKUP, 20'h00000, 20'h00000);
        send_req(OP_INSERT, 20'h00000, 20'hFFFFF);
        send_req(OP_INSERT, 20'hFFFFF, 20'h00000);
        send_req(OP_INSERT, 20'h12345, 20'hABCDE);
        send_req(OP_INSERT, 20'h00000, 20'h00001);
        send_req(OP_LOOKUP, 20'h00000, 20'h00000);
        send_req(OP_LOOKUP, 20'hFFFFF, 20'h00000);
        send_req(OP_INSERT, 20'h00007, 20'h55555);
        send_req(OP_LOOKUP, 20'h00000, 20'h00000);
        send_req(OP_NOP,    20'hAAAAA, 20'h55555);
        send_req(OP_FLUSH,  20'hFFFFF, 20'hFFFFF);
        send_req(OP_LOOKUP, 20'h00007, 20'h00000);

        // LRU: a hit restamps, so the next victim is a different entry
        set_policy(MODE_LRU, 5'd4);
        send_req(OP_INSERT, 20'h00001, 20'h10001);
        send_req(OP_INSERT, 20'h00002, 20'h10002);
        send_req(OP_INSERT, 20'h00003, 20'h10003);
        send_req(OP_INSERT, 20'h00004, 20'h10004);
        send_req(OP_LOOKUP, 20'h00001, 20'h00000);
        send_req(OP_INSERT, 20'h00005, 20'h10005);
        send_req(OP_LOOKUP, 20'h00002, 20'h00000);
        send_req(OP_LOOKUP, 20'h00001, 20'h00000);

        // entries above the count are hidden, then seen again when raised
        set_policy(MODE_LRU, 5'd2);
        send_req(OP_LOOKUP, 20'h00004, 20'h00000);
        send_req(OP_INSERT, 20'h00006, 20'h10006);
        set_policy(MODE_LRU, 5'd16);
        send_req(OP_LOOKUP, 20'h00004, 20'h00000);

        for (int p = 0; p < 9; p++) begin
            // last phase runs without stalls; leftover bursts drain
            // during the register writes
            if (p == 8) begin
                calm    = 1'b1;
                gap_pct = 0;
            end
            set_policy(modes[p], counts[p]);
            gap_pct = (p % 3 == 2) ? 0 : 20;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // long response stall while requests keep coming
                if (p == 1 && k == 20) begin
                    hold_req = 1'b1;
                    gap_pct  = 0;
                end
                if (p == 3 && k == 30)
                    wait_responses();
                random_req();
            end
        end

        wait_responses();
        repeat (SETTLE) @(negedge aclk);

        $display("Covered %0d requests over %0d table settings (FIFO/LRU, entry counts 0..31).",
                 sent, settings);
        $display("Checked %0d responses: %0d hits, %0d replacements of a valid entry.",
                 checked, hits, evictions);
        if (errors == 0)
            $display("PASS tlb_fifo_lru_replacement_unit");
        else
            $display("FAIL tlb_fifo_lru_replacement_unit");
        $finish;
    end

endmodule
